### rtl/tpkd_pkg.sv
// ----------------------------------------------------------------------------
// tpkd_pkg
// Shared constants, codes and types of the two-part text key decoder.
// ----------------------------------------------------------------------------
package tpkd_pkg;

   localparam int unsigned MAX_BYTES = 4096;
   localparam int unsigned CNT_BITS  = $clog2(MAX_BYTES + 2);
   localparam int unsigned LIM_W     = (CNT_BITS > 13) ? CNT_BITS : 13;

   localparam int unsigned CFG_W   = 13;
   localparam int unsigned VER_W   = 8;
   localparam int unsigned LEN_W   = 13;
   localparam int unsigned SHIFT_W = 32;

   localparam logic [LEN_W-1:0] LEN_SAT = 13'd8191;

   localparam logic [0:0] CSR_FORMAT_VERSION = 1'b0;
   localparam logic [0:0] CSR_MAX_KEY_BYTES  = 1'b1;

   localparam logic [VER_W-1:0] VERSION_RESET = 8'd1;
   localparam logic [CFG_W-1:0] MAX_KEY_RESET = 13'd4096;

   localparam logic [7:0] HDR_M       = 8'h4D;
   localparam logic [7:0] HDR_G       = 8'h47;
   localparam logic [7:0] HDR_K       = 8'h4B;
   localparam logic [7:0] HDR_ARITY   = 8'd2;
   localparam logic [7:0] HDR_RSVD    = 8'd0;
   localparam logic [7:0] PART_TYPE   = 8'd1;
   localparam logic [7:0] FLAG_SET    = 8'd1;
   localparam int unsigned HDR_BYTES  = 6;

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_PART    = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_HALT    = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SIZE    = 3'd1;
   localparam logic [2:0] ST_HEADER  = 3'd2;
   localparam logic [2:0] ST_FIRST   = 3'd3;
   localparam logic [2:0] ST_SECOND  = 3'd4;
   localparam logic [2:0] ST_TRAIL   = 3'd5;

   localparam logic [2:0] POS_M       = 3'd0;
   localparam logic [2:0] POS_G       = 3'd1;
   localparam logic [2:0] POS_K       = 3'd2;
   localparam logic [2:0] POS_VERSION = 3'd3;
   localparam logic [2:0] POS_ARITY   = 3'd4;
   localparam logic [2:0] POS_RSVD    = 3'd5;
   localparam logic [2:0] POS_TYPE    = 3'd0;
   localparam logic [2:0] POS_FLAG    = 3'd1;
   localparam logic [2:0] POS_LEN0    = 3'd2;
   localparam logic [2:0] POS_LEN3    = 3'd5;

   typedef struct packed {
      logic [2:0]         phase;
      logic [2:0]         field_pos;
      logic               part;
      logic [SHIFT_W-1:0] length_shift;
      logic [SHIFT_W-1:0] payload_left;
      logic [LIM_W-1:0]   byte_count;
      logic [2:0]         first_error;
      logic [1:0]         part_flags;
      logic [LEN_W-1:0]   len0;
      logic [LEN_W-1:0]   len1;
   } state_type;

   typedef struct packed {
      logic             payload_strobe;
      logic             part_index;
      logic [7:0]       payload_byte;
      logic             key_done;
      logic [2:0]       status;
      logic             first_present;
      logic [LEN_W-1:0] first_length;
      logic             second_present;
      logic [LEN_W-1:0] second_length;
   } result_type;

endpackage

### rtl/tpkd_req_if.sv
// ----------------------------------------------------------------------------
// tpkd_req_if
// Key byte channel: one encoded key byte per item with a last-byte flag.
// ----------------------------------------------------------------------------
interface tpkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_byte;
   logic       final_byte;

   modport source (output valid, output key_byte, output final_byte, input ready);
   modport sink   (input valid, input key_byte, input final_byte, output ready);
endinterface

### rtl/tpkd_rsp_if.sv
// ----------------------------------------------------------------------------
// tpkd_rsp_if
// Result channel: payload byte and, on the last byte, the key status.
// ----------------------------------------------------------------------------
interface tpkd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       payload_strobe;
   logic                       part_index;
   logic [7:0]                 payload_byte;
   logic                       key_done;
   logic [2:0]                 status;
   logic                       first_present;
   logic [tpkd_pkg::LEN_W-1:0] first_length;
   logic                       second_present;
   logic [tpkd_pkg::LEN_W-1:0] second_length;

   modport source (output valid, output payload_strobe, output part_index,
                   output payload_byte, output key_done, output status,
                   output first_present, output first_length,
                   output second_present, output second_length, input ready);
   modport sink   (input valid, input payload_strobe, input part_index,
                   input payload_byte, input key_done, input status,
                   input first_present, input first_length,
                   input second_present, input second_length, output ready);
endinterface

### rtl/tpkd_step.sv
// ----------------------------------------------------------------------------
// tpkd_step
// Parser next-state and result logic for one key byte.
// ----------------------------------------------------------------------------
module tpkd_step (
   input  tpkd_pkg::state_type             cur,
   input  logic [7:0]                      key_byte,
   input  logic                            final_byte,
   input  logic [tpkd_pkg::VER_W-1:0]      version,
   input  logic [tpkd_pkg::LIM_W-1:0]      limit,
   output tpkd_pkg::state_type             nxt,
   output tpkd_pkg::result_type            res
);

   tpkd_pkg::state_type            st;
   logic [7:0]                     want;
   logic [2:0]                     perr;
   logic [tpkd_pkg::SHIFT_W-1:0]   shifted;
   logic [tpkd_pkg::LEN_W-1:0]     len_sat;
   logic                           flag_cur;
   logic [2:0]                     fin_status;

   always_comb begin
      st       = cur;
      perr     = cur.part ? tpkd_pkg::ST_SECOND : tpkd_pkg::ST_FIRST;
      shifted  = {cur.length_shift[tpkd_pkg::SHIFT_W-9:0], key_byte};
      len_sat  = (shifted > tpkd_pkg::SHIFT_W'(tpkd_pkg::LEN_SAT)) ?
                 tpkd_pkg::LEN_SAT : shifted[tpkd_pkg::LEN_W-1:0];
      flag_cur = cur.part ? cur.part_flags[1] : cur.part_flags[0];

      case (cur.field_pos)
         tpkd_pkg::POS_M:       want = tpkd_pkg::HDR_M;
         tpkd_pkg::POS_G:       want = tpkd_pkg::HDR_G;
         tpkd_pkg::POS_K:       want = tpkd_pkg::HDR_K;
         tpkd_pkg::POS_VERSION: want = version;
         tpkd_pkg::POS_ARITY:   want = tpkd_pkg::HDR_ARITY;
         default:               want = tpkd_pkg::HDR_RSVD;
      endcase

      res = '0;

      if (cur.byte_count <= limit) begin
         st.byte_count = cur.byte_count + tpkd_pkg::LIM_W'(1);
      end

      case (cur.phase)
         tpkd_pkg::PH_HEADER: begin
            if (key_byte != want) begin
               if (cur.first_error == tpkd_pkg::ST_OK) st.first_error = tpkd_pkg::ST_HEADER;
               st.phase = tpkd_pkg::PH_HALT;
            end else if (cur.field_pos >= tpkd_pkg::POS_RSVD) begin
               st.phase        = tpkd_pkg::PH_PART;
               st.field_pos    = tpkd_pkg::POS_TYPE;
               st.part         = 1'b0;
               st.length_shift = '0;
            end else begin
               st.field_pos = cur.field_pos + 3'd1;
            end
         end
         tpkd_pkg::PH_PART: begin
            if (cur.field_pos == tpkd_pkg::POS_TYPE) begin
               if (key_byte != tpkd_pkg::PART_TYPE) begin
                  if (cur.first_error == tpkd_pkg::ST_OK) st.first_error = perr;
                  st.phase = tpkd_pkg::PH_HALT;
               end else begin
                  st.field_pos = tpkd_pkg::POS_FLAG;
               end
            end else if (cur.field_pos == tpkd_pkg::POS_FLAG) begin
               if (key_byte > tpkd_pkg::FLAG_SET) begin
                  if (cur.first_error == tpkd_pkg::ST_OK) st.first_error = perr;
                  st.phase = tpkd_pkg::PH_HALT;
               end else begin
                  if (key_byte == tpkd_pkg::FLAG_SET) begin
                     if (cur.part) st.part_flags[1] = 1'b1;
                     else          st.part_flags[0] = 1'b1;
                  end
                  st.field_pos = tpkd_pkg::POS_LEN0;
               end
            end else begin
               st.length_shift = shifted;
               if (cur.field_pos < tpkd_pkg::POS_LEN3) begin
                  st.field_pos = cur.field_pos + 3'd1;
               end else begin
                  if (cur.part) st.len1 = len_sat;
                  else          st.len0 = len_sat;
                  if (!flag_cur && shifted != '0) begin
                     if (cur.first_error == tpkd_pkg::ST_OK) st.first_error = perr;
                     st.phase = tpkd_pkg::PH_HALT;
                  end else if (shifted == '0) begin
                     st.field_pos    = tpkd_pkg::POS_TYPE;
                     st.length_shift = '0;
                     st.part         = 1'b1;
                     st.phase        = cur.part ? tpkd_pkg::PH_DONE : tpkd_pkg::PH_PART;
                  end else begin
                     st.payload_left = shifted;
                     st.phase        = tpkd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         tpkd_pkg::PH_PAYLOAD: begin
            res.payload_strobe = 1'b1;
            res.part_index     = cur.part;
            res.payload_byte   = key_byte;
            st.payload_left    = cur.payload_left - tpkd_pkg::SHIFT_W'(1);
            if (cur.payload_left == tpkd_pkg::SHIFT_W'(1)) begin
               st.field_pos    = tpkd_pkg::POS_TYPE;
               st.length_shift = '0;
               st.part         = 1'b1;
               st.phase        = cur.part ? tpkd_pkg::PH_DONE : tpkd_pkg::PH_PART;
            end
         end
         tpkd_pkg::PH_DONE: begin
            if (cur.first_error == tpkd_pkg::ST_OK) st.first_error = tpkd_pkg::ST_TRAIL;
            st.phase = tpkd_pkg::PH_HALT;
         end
         default: begin
         end
      endcase

      if (st.byte_count < tpkd_pkg::LIM_W'(tpkd_pkg::HDR_BYTES) || st.byte_count > limit) begin
         fin_status = tpkd_pkg::ST_SIZE;
      end else if (st.first_error != tpkd_pkg::ST_OK) begin
         fin_status = st.first_error;
      end else if (st.phase == tpkd_pkg::PH_DONE) begin
         fin_status = tpkd_pkg::ST_OK;
      end else begin
         fin_status = st.part ? tpkd_pkg::ST_SECOND : tpkd_pkg::ST_FIRST;
      end

      if (final_byte) begin
         res.key_done       = 1'b1;
         res.status         = fin_status;
         res.first_present  = st.part_flags[0];
         res.first_length   = st.len0;
         res.second_present = st.part_flags[1];
         res.second_length  = st.len1;
         st                 = '0;
         st.phase           = tpkd_pkg::PH_HEADER;
      end

      nxt = st;
   end

endmodule

### rtl/text_pair_key_decoder.sv
// ----------------------------------------------------------------------------
// text_pair_key_decoder
// Validates and splits an encoded two-part text key, one byte per item.
//
//   channel  dir  handshake      content
//   req_if   in   valid/ready    key_byte, final_byte
//   rsp_if   out  valid/ready    payload byte, part index, status on last byte
//   csr_*    in   write enable   format_version (0), max_key_bytes (1)
//
// One item per cycle while the result is not stalled; the result appears in the
// cycle after the item is taken, from the result register. The parser state
// update is combinational logic feeding the state registers. Synchronous
// active-high reset clears the parser and loads register defaults. A stalled
// result holds; a new item is taken in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module text_pair_key_decoder (
   input  logic                        clock,
   input  logic                        reset,
   tpkd_req_if.sink                    req_if,
   tpkd_rsp_if.source                  rsp_if,
   input  logic                        csr_write_en,
   input  logic [0:0]                  csr_index,
   input  logic [tpkd_pkg::CFG_W-1:0]  csr_wdata
);

   logic [tpkd_pkg::VER_W-1:0] version_ff;
   logic [tpkd_pkg::CFG_W-1:0] max_key_ff;
   logic [tpkd_pkg::LIM_W-1:0] limit;

   tpkd_pkg::state_type  state_ff;
   tpkd_pkg::state_type  state_in;
   tpkd_pkg::result_type result_in;
   tpkd_pkg::result_type result_ff;
   logic                 rsp_valid_ff;
   logic                 accept;

   assign limit = (tpkd_pkg::LIM_W'(max_key_ff) < tpkd_pkg::LIM_W'(tpkd_pkg::MAX_BYTES)) ?
                  tpkd_pkg::LIM_W'(max_key_ff) : tpkd_pkg::LIM_W'(tpkd_pkg::MAX_BYTES);

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   tpkd_step u_step (
      .cur        (state_ff),
      .key_byte   (req_if.key_byte),
      .final_byte (req_if.final_byte),
      .version    (version_ff),
      .limit      (limit),
      .nxt        (state_in),
      .res        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= tpkd_pkg::VERSION_RESET;
         max_key_ff <= tpkd_pkg::MAX_KEY_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tpkd_pkg::CSR_FORMAT_VERSION: version_ff <= csr_wdata[tpkd_pkg::VER_W-1:0];
            tpkd_pkg::CSR_MAX_KEY_BYTES:  max_key_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // all-zero state is the header phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.payload_strobe = result_ff.payload_strobe;
   assign rsp_if.part_index     = result_ff.part_index;
   assign rsp_if.payload_byte   = result_ff.payload_byte;
   assign rsp_if.key_done       = result_ff.key_done;
   assign rsp_if.status         = result_ff.status;
   assign rsp_if.first_present  = result_ff.first_present;
   assign rsp_if.first_length   = result_ff.first_length;
   assign rsp_if.second_present = result_ff.second_present;
   assign rsp_if.second_length  = result_ff.second_length;

`ifndef SYNTHESIS
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.final_byte |=>
         state_ff.phase == tpkd_pkg::PH_HEADER && state_ff.byte_count == '0)
      else $error("parser not cleared after last byte");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item gave no result");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tpkd_pkg::PH_PAYLOAD |-> state_ff.payload_left != '0)
      else $error("payload phase with nothing left");

   a_halt_error: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tpkd_pkg::PH_HALT |-> state_ff.first_error != tpkd_pkg::ST_OK)
      else $error("halted without an error code");
`endif

endmodule

### dv/text_pair_key_decoder_test.sv
// ----------------------------------------------------------------------------
// text_pair_key_decoder_test
// Self-checking bench for the two-part text key decoder. Keys are built as
// byte streams, about half well formed with random payload, the rest corrupted,
// cut short, padded or plain noise. Each accepted byte is run through a
// cycle-free model of the parser, and every result item is checked against
// the oldest prediction. The run steps through several register settings
// and idle patterns, including a long result stall that backs up the input.
// ----------------------------------------------------------------------------
package tpkd_check_pkg;
   import tpkd_pkg::*;

   class key_result_board;
      logic [VER_W-1:0] version;
      logic [CFG_W-1:0] max_key;

      logic [2:0]         stage;
      logic [2:0]         field_idx;
      logic               part_sel;
      logic [SHIFT_W-1:0] len_acc;
      logic [SHIFT_W-1:0] bytes_left;
      int unsigned        key_count;
      logic [2:0]         err_code;
      logic [1:0]         present_bits;
      logic [LEN_W-1:0]   part_len [2];

      result_type expected_results[$];
      int mismatches;
      int bytes_in;
      int results_out;
      int keys_closed;
      int payload_seen;
      int status_hits [8];

      function new();
         version = VERSION_RESET;
         max_key = MAX_KEY_RESET;
         clear_key();
      endfunction

      function void clear_key();
         stage        = PH_HEADER;
         field_idx    = POS_M;
         part_sel     = 1'b0;
         len_acc      = '0;
         bytes_left   = '0;
         key_count    = 0;
         err_code     = ST_OK;
         present_bits = '0;
         part_len[0]  = '0;
         part_len[1]  = '0;
      endfunction

      function void set_config(logic [0:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_FORMAT_VERSION) version = val[VER_W-1:0];
         else max_key = val;
      endfunction

      function void mark_error(logic [2:0] code);
         if (err_code == ST_OK) err_code = code;
         stage = PH_HALT;
      endfunction

      function void next_component();
         field_idx = POS_TYPE;
         len_acc   = '0;
         if (part_sel == 1'b0) begin
            part_sel = 1'b1;
            stage    = PH_PART;
         end else begin
            stage = PH_DONE;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         result_type  r;
         int unsigned lim;
         logic [2:0]  part_err;
         logic [7:0]  want;
         r = '0;
         lim = (max_key < MAX_BYTES) ? max_key : MAX_BYTES;
         part_err = (part_sel == 1'b0) ? ST_FIRST : ST_SECOND;
         if (key_count <= lim) key_count++;
         case (stage)
            PH_HEADER: begin
               case (field_idx)
                  POS_M:       want = HDR_M;
                  POS_G:       want = HDR_G;
                  POS_K:       want = HDR_K;
                  POS_VERSION: want = version;
                  POS_ARITY:   want = HDR_ARITY;
                  default:     want = HDR_RSVD;
               endcase
               if (b != want) begin
                  mark_error(ST_HEADER);
               end else if (field_idx >= POS_RSVD) begin
                  stage     = PH_PART;
                  field_idx = POS_TYPE;
                  part_sel  = 1'b0;
                  len_acc   = '0;
               end else begin
                  field_idx++;
               end
            end
            PH_PART: begin
               if (field_idx == POS_TYPE) begin
                  if (b != PART_TYPE) mark_error(part_err);
                  else field_idx = POS_FLAG;
               end else if (field_idx == POS_FLAG) begin
                  if (b > FLAG_SET) begin
                     mark_error(part_err);
                  end else begin
                     if (b == FLAG_SET) present_bits[part_sel] = 1'b1;
                     field_idx = POS_LEN0;
                  end
               end else begin
                  len_acc = {len_acc[SHIFT_W-9:0], b};
                  if (field_idx < POS_LEN3) begin
                     field_idx++;
                  end else begin
                     part_len[part_sel] = (len_acc > SHIFT_W'(LEN_SAT)) ?
                                          LEN_SAT : len_acc[LEN_W-1:0];
                     if (!present_bits[part_sel] && len_acc != 0) begin
                        mark_error(part_err);
                     end else if (len_acc == 0) begin
                        next_component();
                     end else begin
                        bytes_left = len_acc;
                        stage      = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               r.payload_strobe = 1'b1;
               r.part_index     = part_sel;
               r.payload_byte   = b;
               payload_seen++;
               bytes_left--;
               if (bytes_left == 0) next_component();
            end
            PH_DONE: mark_error(ST_TRAIL);
            default: ;
         endcase
         if (fin) begin
            r.key_done = 1'b1;
            if (key_count < HDR_BYTES || key_count > lim) r.status = ST_SIZE;
            else if (err_code != ST_OK) r.status = err_code;
            else if (stage == PH_DONE) r.status = ST_OK;
            else r.status = (part_sel == 1'b0) ? ST_FIRST : ST_SECOND;
            r.first_present  = present_bits[0];
            r.first_length   = part_len[0];
            r.second_present = present_bits[1];
            r.second_length  = part_len[1];
            status_hits[r.status]++;
            keys_closed++;
            clear_key();
         end
         expected_results.push_back(r);
         bytes_in++;
      endfunction

      function string fmt(result_type r);
         return $sformatf("strb=%0d part=%0d byte=%02h done=%0d st=%0d p0=%0d l0=%0d p1=%0d l1=%0d",
                          r.payload_strobe, r.part_index, r.payload_byte, r.key_done,
                          r.status, r.first_present, r.first_length, r.second_present,
                          r.second_length);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: %s", fmt(got));
            return;
         end
         want = expected_results.pop_front();
         results_out++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d mismatch\n  expected %s\n  actual   %s",
                        results_out, fmt(want), fmt(got));
         end
      endfunction
   endclass
endpackage

module text_pair_key_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tpkd_pkg::*;
   import tpkd_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 48;
   localparam int PHASE_BYTES    = 160;
   localparam int NUM_PHASES     = 7;

   logic clock;
   logic reset;
   logic             csr_write_en;
   logic [0:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;

   tpkd_req_if req_if ();
   tpkd_rsp_if rsp_if ();

   text_pair_key_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   key_result_board sb;
   logic [7:0] key_bytes[$];
   result_type got;
   int sent;
   int tx_idle_pct;
   int rx_stall_pct;
   int hold_req;
   int hold_ack;
   int hold_left;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic write_csr(logic [0:0] idx, logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_config(idx, data);
   endtask

   task automatic send_item(logic [7:0] b, logic fin);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.key_byte   <= b;
      req_if.final_byte <= fin;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_byte(b, fin);
      sent++;
   endtask

   task automatic send_key();
      for (int i = 0; i < key_bytes.size(); i++)
         send_item(key_bytes[i], i == key_bytes.size() - 1);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic void push_len(logic [31:0] len);
      key_bytes.push_back(len[31:24]);
      key_bytes.push_back(len[23:16]);
      key_bytes.push_back(len[15:8]);
      key_bytes.push_back(len[7:0]);
   endfunction

   // about half well-formed keys; the rest broken in one place or pure noise
   function automatic void make_key(logic [7:0] ver);
      int          mode;
      int          n;
      int          s;
      int          part_start [2];
      logic        present;
      int unsigned plen;
      logic [31:0] big;
      key_bytes.delete();
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         n = $urandom_range(1, 12);
         repeat (n) key_bytes.push_back(8'($urandom));
         return;
      end
      key_bytes.push_back(HDR_M);
      key_bytes.push_back(HDR_G);
      key_bytes.push_back(HDR_K);
      key_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : ver);
      key_bytes.push_back(HDR_ARITY);
      key_bytes.push_back(HDR_RSVD);
      for (int p = 0; p < 2; p++) begin
         present = ($urandom_range(0, 3) != 0);
         if (!present) plen = 0;
         else if ($urandom_range(0, 5) == 0) plen = $urandom_range(9, 40);
         else plen = $urandom_range(0, 6);
         part_start[p] = key_bytes.size();
         key_bytes.push_back(PART_TYPE);
         key_bytes.push_back({7'd0, present});
         push_len(plen);
         repeat (plen) key_bytes.push_back(8'($urandom));
      end
      s = part_start[$urandom_range(0, 1)];
      if (mode < 20) begin
         key_bytes[$urandom_range(0, key_bytes.size() - 1)] = 8'($urandom);
      end else if (mode < 30) begin
         n = $urandom_range(1, key_bytes.size() - 1);
         while (key_bytes.size() > n) void'(key_bytes.pop_back());
      end else if (mode < 37) begin
         n = $urandom_range(1, 3);
         repeat (n) key_bytes.push_back(8'($urandom));
      end else if (mode < 42) begin
         key_bytes[s + $urandom_range(0, 1)] = 8'($urandom_range(2, 255));
      end else if (mode < 47) begin
         key_bytes[s + 1] = 8'd0;
         key_bytes[s + 5] = 8'($urandom_range(1, 255));
      end else if (mode < 52) begin
         // length far beyond the bytes that follow
         if ($urandom_range(0, 1) == 1) big = {8'($urandom_range(1, 255)), 24'($urandom)};
         else big = $urandom_range(4097, 9000);
         key_bytes[s + 1] = FLAG_SET;
         key_bytes[s + 2] = big[31:24];
         key_bytes[s + 3] = big[23:16];
         key_bytes[s + 4] = big[15:8];
         key_bytes[s + 5] = big[7:0];
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         idle_cycles = 0;
         hold_ack    = 0;
         hold_left   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.payload_strobe = rsp_if.payload_strobe;
            got.part_index     = rsp_if.part_index;
            got.payload_byte   = rsp_if.payload_byte;
            got.key_done       = rsp_if.key_done;
            got.status         = rsp_if.status;
            got.first_present  = rsp_if.first_present;
            got.first_length   = rsp_if.first_length;
            got.second_present = rsp_if.second_present;
            got.second_length  = rsp_if.second_length;
            sb.check_result(got);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end else begin
            if (hold_req != hold_ack) begin
               hold_ack  = hold_req;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
         end
      end
   end

   initial begin
      int start;
      bit held;
      sb = new();
      sent = 0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_req = 0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.key_byte   <= '0;
      req_if.final_byte <= 1'b0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_FORMAT_VERSION;
      csr_wdata         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // header cut short of the minimum size, then a complete valid key
      key_bytes = '{HDR_M, HDR_G, HDR_K, VERSION_RESET, HDR_ARITY};
      send_key();
      key_bytes = '{HDR_M, HDR_G, HDR_K, VERSION_RESET, HDR_ARITY, HDR_RSVD,
                    PART_TYPE, FLAG_SET, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF,
                    PART_TYPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_key();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         case (ph)
            1: write_csr(CSR_FORMAT_VERSION, 13'h0FF);
            2: begin
               write_csr(CSR_FORMAT_VERSION, 13'h000);
               write_csr(CSR_MAX_KEY_BYTES, 13'd6);
            end
            3: begin
               write_csr(CSR_FORMAT_VERSION, CFG_W'($urandom_range(0, 255)));
               write_csr(CSR_MAX_KEY_BYTES, CFG_W'($urandom_range(18, 60)));
            end
            4: begin
               write_csr(CSR_FORMAT_VERSION, 13'h05A);
               write_csr(CSR_MAX_KEY_BYTES, 13'h1FFF);
            end
            5: begin
               write_csr(CSR_FORMAT_VERSION, CFG_W'($urandom_range(0, 255)));
               write_csr(CSR_MAX_KEY_BYTES, CFG_W'($urandom_range(0, 5)));
            end
            6: begin
               write_csr(CSR_FORMAT_VERSION, CFG_W'(VERSION_RESET));
               write_csr(CSR_MAX_KEY_BYTES, MAX_KEY_RESET);
            end
            default: ;
         endcase
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
            default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
         endcase
         start = sent;
         held = 0;
         while (sent - start < PHASE_BYTES) begin
            if (!held && (ph == 3 || ph == 4) && sent - start >= 40) begin
               hold_req++;
               held = 1;
            end
            make_key(sb.version);
            send_key();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("%0d key bytes, %0d keys: ok %0d size %0d header %0d first %0d second %0d trail %0d",
               sb.bytes_in, sb.keys_closed, sb.status_hits[ST_OK], sb.status_hits[ST_SIZE],
               sb.status_hits[ST_HEADER], sb.status_hits[ST_FIRST],
               sb.status_hits[ST_SECOND], sb.status_hits[ST_TRAIL]);
      $display("%0d payload bytes over %0d register settings, %0d mismatches",
               sb.payload_seen, NUM_PHASES, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

### files.f
rtl/tpkd_pkg.sv
rtl/tpkd_req_if.sv
rtl/tpkd_rsp_if.sv
rtl/tpkd_step.sv
rtl/text_pair_key_decoder.sv
dv/text_pair_key_decoder_test.sv
